>>> rtl/core/tbs_pkg.sv
package tbs_pkg;

  // Table and field geometry
  localparam int TRACK_SLOTS = 256;
  localparam int ID_BITS     = 8;
  localparam int COORD_BITS  = 16;
  localparam int EDGES       = 4;
  localparam int HIST_DEPTH  = 3;
  localparam int CNT_BITS    = 2;
  localparam int WEIGHT_BITS = 4;
  localparam int BOX_BITS    = EDGES * COORD_BITS;
  localparam int ROW_BITS    = HIST_DEPTH * BOX_BITS + CNT_BITS;

  // Weighted sum of four terms, weights summing to ten, plus rounding
  localparam int SUM_BITS    = 20;
  localparam int ROUND_HALF  = 5;

  // Divide by ten as multiply by ceil(2^23 / 10) and shift; exact below 2^22
  localparam int DIV_SHIFT   = 23;
  localparam int DIV_MULT    = 838861;
  localparam int PROD_BITS   = 2 * SUM_BITS;

  typedef logic [EDGES-1:0][COORD_BITS-1:0] box_t;
  typedef logic [HIST_DEPTH:0][WEIGHT_BITS-1:0] weight_row_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic sum;
    logic div;
    logic write;
  } tbs_cmd_t;

  // Weights in tenths, element 0 applies to the new box, then newest history first
  function automatic weight_row_t weight_row(input logic [CNT_BITS-1:0] used);
    weight_row_t row;
    unique case (used)
      2'd0:    row = {4'd0, 4'd0, 4'd0, 4'd10};
      2'd1:    row = {4'd0, 4'd0, 4'd2, 4'd8};
      2'd2:    row = {4'd0, 4'd2, 4'd3, 4'd5};
      default: row = {4'd1, 4'd2, 4'd3, 4'd4};
    endcase
    return row;
  endfunction

endpackage

>>> rtl/core/tbs_ram.sv
module tbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/tbs_ctrl.sv
module tbs_ctrl import tbs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output tbs_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_WB   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Sequence one item through read, sum, divide and write back
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_SUM;
      ST_SUM:  state_next = ST_DIV;
      ST_DIV:  state_next = ST_WB;
      ST_WB:   state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands and status
  assign busy      = (state != ST_IDLE);
  assign done      = (state == ST_WB);
  assign cmd.load  = (state == ST_IDLE) && start;
  assign cmd.sum   = (state == ST_SUM);
  assign cmd.div   = (state == ST_DIV);
  assign cmd.write = (state == ST_WB);

endmodule

>>> rtl/core/tbs_datapath.sv
module tbs_datapath import tbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  tbs_cmd_t              cmd,
  input  logic [ID_BITS-1:0]    track_id,
  input  box_t                  box_in,
  output box_t                  box_out,
  output logic [CNT_BITS-1:0]   used_out
);

  logic [TRACK_SLOTS-1:0]     valid;
  logic                       valid_q;
  logic [ID_BITS-1:0]         id_q;
  box_t                       box_q;
  logic [ROW_BITS-1:0]        rdata;
  logic [ROW_BITS-1:0]        wdata;
  box_t [HIST_DEPTH-1:0]      hist;
  logic [CNT_BITS-1:0]        used;
  logic [CNT_BITS-1:0]        used_q;
  logic [CNT_BITS-1:0]        cnt_new;
  weight_row_t                weights;
  logic [EDGES-1:0][SUM_BITS-1:0] sum_comb;
  logic [EDGES-1:0][SUM_BITS-1:0] sum_q;
  box_t                       res_comb;
  box_t                       res_q;

  // History row per track: count on top, then oldest down to newest
  tbs_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(TRACK_SLOTS)
  ) u_hist_ram (
    .clk  (clk),
    .we   (cmd.write),
    .waddr(id_q),
    .wdata(wdata),
    .re   (cmd.load),
    .raddr(track_id),
    .rdata(rdata)
  );

  // Mark rows that hold a count; unmarked rows count as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.write) begin
      valid[id_q] <= 1'b1;
    end
  end

  // Capture the item at accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_q    <= track_id;
      box_q   <= box_in;
      valid_q <= valid[track_id];
    end
  end

  assign hist    = rdata[HIST_DEPTH*BOX_BITS-1:0];
  assign used    = valid_q ? rdata[ROW_BITS-1 -: CNT_BITS] : '0;
  assign weights = weight_row(used);

  // Weighted sum per edge plus rounding half, unused history gated to zero
  always_comb begin
    for (int e = 0; e < EDGES; e++) begin
      sum_comb[e] = SUM_BITS'(weights[0]) * SUM_BITS'(box_q[e]) + SUM_BITS'(ROUND_HALF);
      for (int k = 0; k < HIST_DEPTH; k++) begin
        if (CNT_BITS'(k) < used) begin
          sum_comb[e] = sum_comb[e] + SUM_BITS'(weights[k+1]) * SUM_BITS'(hist[k][e]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum_q  <= sum_comb;
      used_q <= used;
    end
  end

  // Divide each edge sum by ten through the reciprocal
  always_comb begin
    for (int e = 0; e < EDGES; e++) begin
      logic [PROD_BITS-1:0] prod;
      prod        = PROD_BITS'(sum_q[e]) * PROD_BITS'(DIV_MULT);
      res_comb[e] = prod[DIV_SHIFT +: COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div) begin
      res_q <= res_comb;
    end
  end

  // Slide the window: result becomes newest, oldest drops off
  assign cnt_new = (used_q == CNT_BITS'(HIST_DEPTH)) ? used_q : used_q + 1'b1;
  assign wdata   = {cnt_new, hist[1], hist[0], res_q};

  assign box_out  = res_q;
  assign used_out = used_q;

endmodule

>>> rtl/core/track_box_smoother.sv
// Smooths detection boxes per track. Pulse start with a box while busy is low;
// the history row is read at the accepting edge, the next cycle forms the weighted
// sum, the one after divides by ten, and then done is high for exactly one cycle
// with the smoothed edges and history_used. The next box may be started in the
// cycle after done. No new box is taken until the last one is written back, as
// the read-modify-write of the one history row per track requires. The receiver
// cannot stall: it must take the result in the single cycle that done is high.
// Track history is empty after reset.
module track_box_smoother import tbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ID_BITS-1:0]    track_id,
  input  logic [15:0]           box_left,
  input  logic [15:0]           box_top,
  input  logic [15:0]           box_right,
  input  logic [15:0]           box_bottom,
  output logic                  done,
  output logic [15:0]           smooth_left,
  output logic [15:0]           smooth_top,
  output logic [15:0]           smooth_right,
  output logic [15:0]           smooth_bottom,
  output logic [1:0]            history_used
);

  tbs_cmd_t cmd;
  box_t     box_in;
  box_t     box_out;

  assign box_in = {box_bottom, box_right, box_top, box_left};

  tbs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .cmd  (cmd)
  );

  tbs_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .track_id(track_id),
    .box_in  (box_in),
    .box_out (box_out),
    .used_out(history_used)
  );

  assign smooth_left   = box_out[0];
  assign smooth_top    = box_out[1];
  assign smooth_right  = box_out[2];
  assign smooth_bottom = box_out[3];

endmodule

>>> rtl/core/tbs_checker.sv
module tbs_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done
);

  // An accepted item blocks further items
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // An accepted item is always followed by a result strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##3 done)
    else $error("result missing three cycles after accept");

  // Result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // Block frees up right after a result
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy still high after result");

  // A result is only shown while the item is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without an item in flight");

endmodule

bind track_box_smoother tbs_checker u_tbs_checker (.*);
